// ===== rtl/core/tlik_pkg.sv =====
package tlik_pkg;

	localparam int LEN_W      = 23;
	localparam int CRD_W      = 24;
	localparam int CORDIC_W   = 44;
	localparam int Z_W        = 34;
	localparam int ANG_W      = 33;
	localparam int OPND_W     = 56;
	localparam int SQ_W       = 61;
	localparam int D_W        = 30;
	localparam int N_W        = 32;
	localparam int NORM_MSB   = 40;
	localparam int DEN_MSB    = 29;
	localparam int SQRT_CELLS = 30;

	localparam logic signed [Z_W-1:0] QUARTER_TURN = 34'sh040000000;
	localparam logic signed [Z_W-1:0] HALF_TURN    = 34'sh080000000;

	typedef enum logic {
		REG_UPPER_ARM = 1'b0,
		REG_FOREARM   = 1'b1
	} cfg_reg_t;

	// arctan(2^-i) in turns * 2^32
	localparam logic [31:0] ATAN_TABLE [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic signed [CORDIC_W-1:0] x;
		logic signed [CORDIC_W-1:0] y;
		logic signed [Z_W-1:0]      z;
	} cordic_t;

	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [SQ_W-1:0] root;
	} sqrt_t;

	typedef struct packed {
		logic neg_a;
		logic neg_b;
		logic zero;
	} quad_t;

	function automatic logic [5:0] msb_index(input logic [63:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) p = 6'(i);
		end
		return p;
	endfunction

endpackage

// ===== rtl/core/tlik_if.sv =====
interface tlik_tgt_if;
	logic                                valid;
	logic                                ready;
	logic signed [tlik_pkg::CRD_W-1:0]   target_x;
	logic signed [tlik_pkg::CRD_W-1:0]   target_y;
	modport source(output valid, target_x, target_y, input ready);
	modport sink(input valid, target_x, target_y, output ready);
endinterface

interface tlik_res_if;
	logic               valid;
	logic               ready;
	logic               reach_status;
	logic signed [13:0] shoulder_steps;
	logic [11:0]        elbow_steps;
	modport source(output valid, reach_status, shoulder_steps, elbow_steps, input ready);
	modport sink(input valid, reach_status, shoulder_steps, elbow_steps, output ready);
endinterface

// ===== rtl/core/tlik_sqrt_cell.sv =====
module tlik_sqrt_cell #(
	parameter int K = 0
) (
	input  logic            clk,
	input  logic            en,
	input  tlik_pkg::sqrt_t d,
	output tlik_pkg::sqrt_t q
);
	localparam int SH = 2 * (tlik_pkg::SQRT_CELLS - 1 - K);
	localparam logic [tlik_pkg::SQ_W-1:0] BIT = tlik_pkg::SQ_W'(1) << SH;

	tlik_pkg::sqrt_t nxt;
	logic [tlik_pkg::SQ_W-1:0] trial;

	always_comb begin
		trial = d.root + BIT;
		if (d.rem >= trial) begin
			nxt.rem  = d.rem - trial;
			nxt.root = (d.root >> 1) + BIT;
		end else begin
			nxt.rem  = d.rem;
			nxt.root = d.root >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) q <= nxt;
	end
endmodule

// ===== rtl/core/tlik_cordic_cell.sv =====
module tlik_cordic_cell #(
	parameter int I = 0
) (
	input  logic              clk,
	input  logic              en,
	input  tlik_pkg::cordic_t d,
	output tlik_pkg::cordic_t q
);
	localparam logic signed [tlik_pkg::Z_W-1:0] ANG =
		$signed(tlik_pkg::Z_W'(tlik_pkg::ATAN_TABLE[I]));

	tlik_pkg::cordic_t nxt;
	logic signed [tlik_pkg::CORDIC_W-1:0] dx, dy;

	always_comb begin
		dx = d.y >>> I;
		dy = d.x >>> I;
		if (!d.y[tlik_pkg::CORDIC_W-1]) begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + ANG;
		end else begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - ANG;
		end
	end

	always_ff @(posedge clk) begin
		if (en) q <= nxt;
	end
endmodule

// ===== rtl/core/tlik_atan2.sv =====
module tlik_atan2 #(
	parameter int ITER = 16
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [tlik_pkg::OPND_W-1:0] a,
	input  logic signed [tlik_pkg::OPND_W-1:0] b,
	output logic signed [tlik_pkg::ANG_W-1:0]  angle
);
	localparam int W = tlik_pkg::OPND_W;

	logic [W-1:0] ma_s1, mb_s1, ma_s2, mb_s2;
	logic         na_s1, nb_s1, na_s2, nb_s2;
	logic [5:0]   pos_s2;
	logic         zero_s2;
	logic [W-1:0] mx, xn, yn;
	logic [5:0]   sh;

	tlik_pkg::cordic_t stage [ITER+1];
	tlik_pkg::quad_t   quad_q [ITER+1];
	logic signed [tlik_pkg::Z_W-1:0] phi;

	// magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1 <= a[W-1] ? W'(-a) : W'(a);
			mb_s1 <= b[W-1] ? W'(-b) : W'(b);
			na_s1 <= a[W-1];
			nb_s1 <= b[W-1];
		end
	end

	// leading one of the larger magnitude
	assign mx = (ma_s1 > mb_s1) ? ma_s1 : mb_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			ma_s2   <= ma_s1;
			mb_s2   <= mb_s1;
			na_s2   <= na_s1;
			nb_s2   <= nb_s1;
			pos_s2  <= tlik_pkg::msb_index(64'(mx));
			zero_s2 <= (mx == '0);
		end
	end

	// bring the larger one to bit NORM_MSB
	always_comb begin
		if (pos_s2 > 6'(tlik_pkg::NORM_MSB)) begin
			sh = pos_s2 - 6'(tlik_pkg::NORM_MSB);
			xn = mb_s2 >> sh;
			yn = ma_s2 >> sh;
		end else begin
			sh = 6'(tlik_pkg::NORM_MSB) - pos_s2;
			xn = mb_s2 << sh;
			yn = ma_s2 << sh;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage[0].x <= $signed(tlik_pkg::CORDIC_W'(xn));
			stage[0].y <= $signed(tlik_pkg::CORDIC_W'(yn));
			stage[0].z <= '0;
			quad_q[0]  <= '{neg_a: na_s2, neg_b: nb_s2, zero: zero_s2};
			for (int k = 1; k <= ITER; k++) quad_q[k] <= quad_q[k-1];
		end
	end

	for (genvar i = 0; i < ITER; i++) begin : g_cell
		tlik_cordic_cell #(.I(i)) u_cell (
			.clk(clk),
			.en (en),
			.d  (stage[i]),
			.q  (stage[i+1])
		);
	end

	// clamp to the first quadrant, then unfold by the operand signs
	always_comb begin
		if (stage[ITER].z < 0) phi = '0;
		else if (stage[ITER].z > tlik_pkg::QUARTER_TURN) phi = tlik_pkg::QUARTER_TURN;
		else phi = stage[ITER].z;
		if (quad_q[ITER].neg_b) phi = tlik_pkg::HALF_TURN - phi;
		if (quad_q[ITER].neg_a) phi = -phi;
		if (quad_q[ITER].zero) phi = '0;
	end

	always_ff @(posedge clk) begin
		if (en) angle <= tlik_pkg::ANG_W'(phi);
	end
endmodule

// ===== rtl/core/two_link_arm_inverse_kinematics_core.sv =====
// Two-link planar arm inverse kinematics.
// tgt takes one word per target point (target_x, target_y, signed Q15.8);
// res gives one word per point: reach_status, shoulder_steps, elbow_steps.
// Link lengths come from the write port: cfg_index picks the upper arm or
// the forearm, cfg_data carries the 23-bit Q15.8 length. Write only while
// no point is in flight.
// Throughput: one word per cycle while the output is not stalled. The bulk
// of the pipe is the 30-cell square root chain and the CORDIC cell rows of
// the three atan2 units, all of which step together.
// The whole pipe advances when the output register is empty or taken, so
// tgt.ready follows res.ready while a result is waiting; a stalled result
// holds with all words behind it.
// Reset clears the stage valid bits and loads both lengths with 25600.
module two_link_arm_inverse_kinematics_core #(
	parameter int STEPS_PER_REV    = 6400,
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  tlik_pkg::cfg_reg_t            cfg_index,
	input  logic [tlik_pkg::LEN_W-1:0]    cfg_data,
	tlik_tgt_if.sink                      tgt,
	tlik_res_if.source                    res
);
	localparam int ATAN_LAT = ANGLE_ITERATIONS + 4;
	localparam int SQ_END   = 6 + tlik_pkg::SQRT_CELLS;   // valid index of s37
	localparam int LAT      = 6 + tlik_pkg::SQRT_CELLS + 2 + ATAN_LAT + 2;
	localparam int W        = tlik_pkg::OPND_W;

	typedef struct packed {
		logic [tlik_pkg::D_W-1:0]          d;
		logic signed [tlik_pkg::N_W-1:0]   n;
		logic signed [tlik_pkg::CRD_W-1:0] x;
		logic signed [tlik_pkg::CRD_W-1:0] y;
		logic                              oor;
	} side_t;

	logic [tlik_pkg::LEN_W-1:0] l1_q, l2_q;
	logic                       vld_q [LAT];
	logic                       adv;

	// link length registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_q <= tlik_pkg::LEN_W'(25600);
			l2_q <= tlik_pkg::LEN_W'(25600);
		end else if (cfg_we) begin
			unique case (cfg_index)
				tlik_pkg::REG_UPPER_ARM: l1_q <= cfg_data;
				tlik_pkg::REG_FOREARM:   l2_q <= cfg_data;
				default:                 l1_q <= l1_q;
			endcase
		end
	end

	// stall control: one enable for every stage
	assign adv       = !vld_q[LAT-1] || res.ready;
	assign tgt.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) vld_q[k] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= tgt.valid;
			for (int k = 1; k < LAT; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	// s1: squares and link product
	logic signed [tlik_pkg::CRD_W-1:0] x_s1, y_s1;
	logic signed [47:0] xx_s1, yy_s1;
	logic [45:0]        l1l1_s1, l2l2_s1, l1l2_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= tgt.target_x;
			y_s1    <= tgt.target_y;
			xx_s1   <= tgt.target_x * tgt.target_x;
			yy_s1   <= tgt.target_y * tgt.target_y;
			l1l1_s1 <= l1_q * l1_q;
			l2l2_s1 <= l2_q * l2_q;
			l1l2_s1 <= l1_q * l2_q;
		end
	end

	// s2: cosine numerator and denominator, exact
	logic signed [tlik_pkg::CRD_W-1:0] x_s2, y_s2;
	logic signed [48:0] num_s2;
	logic [47:0]        den_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			num_s2 <= 49'(xx_s1) + 49'(yy_s1) - 49'(l1l1_s1) - 49'(l2l2_s1);
			den_s2 <= {l1l2_s1, 1'b0};
		end
	end

	// s3: reach test and leading one of den
	logic signed [tlik_pkg::CRD_W-1:0] x_s3, y_s3;
	logic signed [48:0] num_s3;
	logic [47:0]        den_s3;
	logic [48:0]        num_mag;
	logic [5:0]         pos_s3;
	logic               oor_s3;

	assign num_mag = num_s2[48] ? 49'(-num_s2) : 49'(num_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			num_s3 <= num_s2;
			den_s3 <= den_s2;
			oor_s3 <= (den_s2 == '0) || (num_mag > 49'(den_s2));
			pos_s3 <= tlik_pkg::msb_index(64'(den_s2));
		end
	end

	// s4: scale so den sits in [2^29, 2^30), clamp N to [-D, D]
	logic [5:0]         dsh;
	logic [47:0]        d_w;
	logic signed [48:0] n_w, n_c, d_sg;
	logic signed [tlik_pkg::CRD_W-1:0] x_s4, y_s4;
	logic [tlik_pkg::D_W-1:0]          d_s4;
	logic signed [tlik_pkg::N_W-1:0]   n_s4;
	logic                              oor_s4;

	always_comb begin
		if (pos_s3 > 6'(tlik_pkg::DEN_MSB)) begin
			dsh = pos_s3 - 6'(tlik_pkg::DEN_MSB);
			d_w = den_s3 >> dsh;
			n_w = num_s3 >>> dsh;    // floor
		end else begin
			dsh = 6'(tlik_pkg::DEN_MSB) - pos_s3;
			d_w = den_s3 << dsh;
			n_w = num_s3 <<< dsh;
		end
		d_sg = $signed({1'b0, d_w});
		if (n_w > d_sg) n_c = d_sg;
		else if (n_w < -d_sg) n_c = -d_sg;
		else n_c = n_w;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s4   <= x_s3;
			y_s4   <= y_s3;
			oor_s4 <= oor_s3;
			d_s4   <= d_w[tlik_pkg::D_W-1:0];
			n_s4   <= n_c[tlik_pkg::N_W-1:0];
		end
	end

	// s5: D^2 and N^2
	logic [tlik_pkg::D_W-1:0] n_abs;
	logic [59:0]              dd_s5, nn_s5;
	side_t                    side_s5;

	assign n_abs = n_s4[tlik_pkg::N_W-1] ? tlik_pkg::D_W'(-n_s4) : tlik_pkg::D_W'(n_s4);

	always_ff @(posedge clk) begin
		if (adv) begin
			dd_s5   <= d_s4 * d_s4;
			nn_s5   <= n_abs * n_abs;
			side_s5 <= '{d: d_s4, n: n_s4, x: x_s4, y: y_s4, oor: oor_s4};
		end
	end

	// s6 .. s36: radicand, then one root bit per cell
	tlik_pkg::sqrt_t sq [tlik_pkg::SQRT_CELLS+1];
	side_t           sq_side_q [tlik_pkg::SQRT_CELLS+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			sq[0].rem    <= tlik_pkg::SQ_W'(dd_s5 - nn_s5);
			sq[0].root   <= '0;
			sq_side_q[0] <= side_s5;
			for (int k = 1; k <= tlik_pkg::SQRT_CELLS; k++) sq_side_q[k] <= sq_side_q[k-1];
		end
	end

	for (genvar k = 0; k < tlik_pkg::SQRT_CELLS; k++) begin : g_sqrt
		tlik_sqrt_cell #(.K(k)) u_sqrt (
			.clk(clk),
			.en (adv),
			.d  (sq[k]),
			.q  (sq[k+1])
		);
	end

	side_t                    side_sq;
	logic [tlik_pkg::D_W-1:0] s_sq;

	assign side_sq = sq_side_q[tlik_pkg::SQRT_CELLS];
	assign s_sq    = sq[tlik_pkg::SQRT_CELLS].root[tlik_pkg::D_W-1:0];

	// s37: products for the second shoulder vector
	logic [tlik_pkg::D_W-1:0]          s_s37, d_s37;
	logic signed [tlik_pkg::N_W-1:0]   n_s37;
	logic signed [tlik_pkg::CRD_W-1:0] x_s37, y_s37;
	logic                              oor_s37;
	logic [52:0]                       l2s_s37, l1d_s37;
	logic signed [54:0]                l2n_s37;

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s37   <= s_sq;
			d_s37   <= side_sq.d;
			n_s37   <= side_sq.n;
			x_s37   <= side_sq.x;
			y_s37   <= side_sq.y;
			oor_s37 <= side_sq.oor;
			l2s_s37 <= l2_q * s_sq;
			l1d_s37 <= l1_q * side_sq.d;
			l2n_s37 <= $signed({1'b0, l2_q}) * side_sq.n;
		end
	end

	// s38: atan2 operands
	logic signed [W-1:0] a_el_s38, b_el_s38, a_yx_s38, b_yx_s38, a_3_s38, b_3_s38;
	logic                oor_s38;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_el_s38 <= $signed(W'(s_s37));
			b_el_s38 <= W'(n_s37);
			a_yx_s38 <= W'(y_s37);
			b_yx_s38 <= W'(x_s37);
			a_3_s38  <= $signed(W'(l2s_s37));
			b_3_s38  <= $signed(W'(l1d_s37)) + W'(l2n_s37);
			oor_s38  <= oor_s37;
		end
	end

	// three angle units in lockstep
	logic signed [tlik_pkg::ANG_W-1:0] ang_el, ang_yx, ang_3;
	logic                              oor_dl_q [ATAN_LAT];

	tlik_atan2 #(.ITER(ANGLE_ITERATIONS)) u_atan_el (
		.clk(clk), .en(adv), .a(a_el_s38), .b(b_el_s38), .angle(ang_el)
	);
	tlik_atan2 #(.ITER(ANGLE_ITERATIONS)) u_atan_yx (
		.clk(clk), .en(adv), .a(a_yx_s38), .b(b_yx_s38), .angle(ang_yx)
	);
	tlik_atan2 #(.ITER(ANGLE_ITERATIONS)) u_atan_3 (
		.clk(clk), .en(adv), .a(a_3_s38), .b(b_3_s38), .angle(ang_3)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			oor_dl_q[0] <= oor_s38;
			for (int k = 1; k < ATAN_LAT; k++) oor_dl_q[k] <= oor_dl_q[k-1];
		end
	end

	// t1: shoulder angle, magnitudes
	logic signed [tlik_pkg::Z_W-1:0] sh_diff;
	logic [tlik_pkg::ANG_W-1:0]      sh_mag_t1, el_mag_t1;
	logic                            sh_neg_t1, oor_t1;

	assign sh_diff = tlik_pkg::Z_W'(ang_yx) - tlik_pkg::Z_W'(ang_3);

	always_ff @(posedge clk) begin
		if (adv) begin
			sh_mag_t1 <= sh_diff[tlik_pkg::Z_W-1] ? tlik_pkg::ANG_W'(-sh_diff)
			                                      : tlik_pkg::ANG_W'(sh_diff);
			sh_neg_t1 <= sh_diff[tlik_pkg::Z_W-1];
			el_mag_t1 <= tlik_pkg::ANG_W'(ang_el);
			oor_t1    <= oor_dl_q[ATAN_LAT-1];
		end
	end

	// t2: turns to steps, output register
	logic [63:0] sh_prod, el_prod;
	logic [13:0] sh_steps;

	assign sh_prod  = 64'(sh_mag_t1) * 64'(STEPS_PER_REV);
	assign el_prod  = 64'(el_mag_t1) * 64'(STEPS_PER_REV);
	assign sh_steps = sh_neg_t1 ? 14'(-sh_prod[45:32]) : sh_prod[45:32];

	always_ff @(posedge clk) begin
		if (adv) begin
			res.reach_status   <= oor_t1;
			res.shoulder_steps <= oor_t1 ? '0 : $signed(sh_steps);
			res.elbow_steps    <= oor_t1 ? '0 : el_prod[43:32];
		end
	end

	assign res.valid = vld_q[LAT-1];

	// checks
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.reach_status |-> res.shoulder_steps == 14'sd0 &&
		res.elbow_steps == 12'd0)
		else $error("out-of-reach word carries nonzero steps");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q[0]) && $stable(vld_q[SQ_END]) && $stable(vld_q[LAT-1]))
		else $error("stage valid moved during a stall");

	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[SQ_END] && !oor_s37 |-> s_s37 <= d_s37)
		else $error("elbow sine exceeds scaled denominator");
endmodule

// ===== test/tb_two_link_arm_inverse_kinematics_core.sv =====
`timescale 1ns / 1ps

// Two-link arm inverse kinematics core testbench.
// A local bit-exact solver predicts each result word from the link lengths
// written over the config port; a collector compares every result word with
// the oldest prediction. Both channel sides idle at random.
module tb_two_link_arm_inverse_kinematics_core;

	localparam int  STEPS     = 6400;
	localparam int  ITERS     = 16;
	localparam int  PIPE_WAIT = 80;	// longer than the core latency
	localparam int  MAX_COORD = 8388607;
	localparam int  MAX_LEN   = 8388607;

	localparam longint QTR_TURN  = 64'sh40000000;
	localparam longint HALF_TURN_L = 64'sh80000000;
	localparam longint NORM_HI   = 64'sh20000000000;	// 2^41
	localparam longint NORM_LO   = 64'sh10000000000;	// 2^40

	typedef struct packed {
		logic               reach_status;
		logic signed [13:0] shoulder_steps;
		logic [11:0]        elbow_steps;
	} joint_word_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	tlik_pkg::cfg_reg_t cfg_index;
	logic [tlik_pkg::LEN_W-1:0] cfg_data;

	tlik_tgt_if tgt_bus ();
	tlik_res_if res_bus ();

	two_link_arm_inverse_kinematics_core #(
		.STEPS_PER_REV    (STEPS),
		.ANGLE_ITERATIONS (ITERS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tgt       (tgt_bus),
		.res       (res_bus)
	);

	// solver copy of the link registers
	logic [tlik_pkg::LEN_W-1:0] upper_len;
	logic [tlik_pkg::LEN_W-1:0] fore_len;

	joint_word_t expected_joints[$];
	int          mismatches;
	int          max_gap;	// 0 gives back-to-back words on both sides

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// ---------------- solver ----------------

	function automatic longint unsigned abs_val(longint v);
		return v < 0 ? longint'(0) - v : v;
	endfunction

	// CORDIC vectoring atan2, result in turns * 2^32
	function automatic longint cordic_atan2(longint a, longint b);
		longint unsigned ma, mb;
		longint xv, yv, zv, dx, dy, phi;
		ma = abs_val(a);
		mb = abs_val(b);
		if (ma == 0 && mb == 0)
			return 0;
		// normalize the larger magnitude into [2^40, 2^41)
		while ((ma > mb ? ma : mb) >= NORM_HI) begin
			ma >>= 1;
			mb >>= 1;
		end
		while ((ma > mb ? ma : mb) < NORM_LO) begin
			ma <<= 1;
			mb <<= 1;
		end
		xv = mb;
		yv = ma;
		zv = 0;
		for (int i = 0; i < ITERS; i++) begin
			dx = yv >>> i;	// arithmetic shift floors
			dy = xv >>> i;
			if (yv >= 0) begin
				xv += dx;
				yv -= dy;
				zv += longint'(tlik_pkg::ATAN_TABLE[i]);
			end else begin
				xv -= dx;
				yv += dy;
				zv -= longint'(tlik_pkg::ATAN_TABLE[i]);
			end
		end
		phi = zv < 0 ? 0 : (zv > QTR_TURN ? QTR_TURN : zv);
		if (b < 0)
			phi = HALF_TURN_L - phi;
		return a < 0 ? -phi : phi;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic longint angle_to_steps(longint ang);
		longint s;
		s = longint'((abs_val(ang) * STEPS) >> 32);
		return ang < 0 ? -s : s;
	endfunction

	function automatic joint_word_t solve_joints(logic signed [tlik_pkg::CRD_W-1:0] tx,
			logic signed [tlik_pkg::CRD_W-1:0] ty);
		joint_word_t w;
		longint x, y, l1, l2, num, den, nn, dd, ss, elbow, shoulder;
		int sh;
		longint unsigned mn;
		x   = tx;
		y   = ty;
		l1  = longint'(upper_len);
		l2  = longint'(fore_len);
		num = x * x + y * y - l1 * l1 - l2 * l2;
		den = 2 * l1 * l2;
		w   = '0;
		// zero link length lands here too
		if (den == 0 || abs_val(num) > longint'(den)) begin
			w.reach_status = 1'b1;
			return w;
		end
		sh = 0;
		while ((den >>> sh) >= (longint'(1) << 30))
			sh++;
		dd = den >>> sh;
		nn = num >>> sh;
		while (dd < (longint'(1) << 29)) begin
			dd *= 2;
			nn *= 2;
		end
		if (nn > dd)
			nn = dd;
		if (nn < -dd)
			nn = -dd;
		mn       = abs_val(nn);
		ss       = longint'(int_sqrt(longint'(dd * dd) - mn * mn));
		elbow    = cordic_atan2(ss, nn);
		shoulder = cordic_atan2(y, x) - cordic_atan2(l2 * ss, l1 * dd + l2 * nn);
		w.shoulder_steps = 14'(angle_to_steps(shoulder));
		w.elbow_steps    = 12'(angle_to_steps(elbow));
		return w;
	endfunction

	// ---------------- channel drivers ----------------

	// One target word. Handshake is sampled at the falling edge, where the
	// pipe has settled, and takes effect at the next rising edge.
	task automatic send_target(input logic signed [tlik_pkg::CRD_W-1:0] tx,
			input logic signed [tlik_pkg::CRD_W-1:0] ty);
		int  gap;
		logic hs;
		gap = $urandom_range(0, max_gap);
		if (gap != 0) begin
			tgt_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tgt_bus.valid    <= 1'b1;
		tgt_bus.target_x <= tx;
		tgt_bus.target_y <= ty;
		do begin
			@(negedge clk);
			hs = tgt_bus.ready;
			@(posedge clk);
		end while (!hs);
		expected_joints.push_back(solve_joints(tx, ty));
	endtask

	// Lower valid and wait out every word still in the pipe.
	task automatic drain_pipe();
		tgt_bus.valid <= 1'b0;
		while (expected_joints.size() != 0)
			@(posedge clk);
		repeat (PIPE_WAIT) @(posedge clk);
	endtask

	task automatic write_length(input tlik_pkg::cfg_reg_t idx,
			input logic [tlik_pkg::LEN_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == tlik_pkg::REG_UPPER_ARM)
			upper_len = val;
		else
			fore_len = val;
	endtask

	task automatic set_lengths(input logic [tlik_pkg::LEN_W-1:0] l1,
			input logic [tlik_pkg::LEN_W-1:0] l2);
		drain_pipe();
		write_length(tlik_pkg::REG_UPPER_ARM, l1);
		write_length(tlik_pkg::REG_FOREARM, l2);
	endtask

	// Result collector: random stall, then compare with the oldest prediction.
	initial begin
		joint_word_t got, want;
		logic hs;
		int stall;
		res_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, max_gap);
			if (stall != 0) begin
				res_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			do begin
				@(negedge clk);
				hs  = res_bus.valid && res_bus.ready;
				got = '{res_bus.reach_status, res_bus.shoulder_steps,
					res_bus.elbow_steps};
				@(posedge clk);
			end while (!hs);
			if (expected_joints.size() == 0) begin
				$error("result word with no prediction waiting");
				mismatches++;
			end else begin
				want = expected_joints.pop_front();
				if (got.reach_status !== want.reach_status) begin
					$error("reach_status exp %0d got %0d", want.reach_status,
						got.reach_status);
					mismatches++;
				end
				if (got.shoulder_steps !== want.shoulder_steps) begin
					$error("shoulder_steps exp %0d got %0d", want.shoulder_steps,
						got.shoulder_steps);
					mismatches++;
				end
				if (got.elbow_steps !== want.elbow_steps) begin
					$error("elbow_steps exp %0d got %0d", want.elbow_steps,
						got.elbow_steps);
					mismatches++;
				end
			end
		end
	end

	// ---------------- stimulus ----------------

	function automatic logic signed [tlik_pkg::CRD_W-1:0] rand_coord(input int lim);
		return tlik_pkg::CRD_W'($signed($urandom_range(0, 2 * lim)) - lim);
	endfunction

	// Mostly points inside the reach box of the arm, some full-range noise.
	task automatic send_random_point();
		int lim;
		longint reach;
		reach = longint'(upper_len) + longint'(fore_len);
		lim   = reach > MAX_COORD ? MAX_COORD : int'(reach);
		if ($urandom_range(0, 9) == 0 || lim == 0)
			send_target(tlik_pkg::CRD_W'($urandom), tlik_pkg::CRD_W'($urandom));
		else
			send_target(rand_coord(lim), rand_coord(lim));
	endtask

	// Field extremes, every quadrant, origin, full stretch, folded arm.
	task automatic test_directed_points();
		max_gap = 18;
		send_target(24'sd0, 24'sd0);	// fully folded, elbow half turn
		send_target(24'sd51200, 24'sd0);	// full stretch
		send_target(24'sd0, 24'sd51200);
		send_target(-24'sd51200, 24'sd0);
		send_target(24'sd0, -24'sd51200);
		send_target(24'sd25600, 24'sd25600);
		send_target(-24'sd25600, 24'sd25600);
		send_target(-24'sd25600, -24'sd25600);
		send_target(24'sd25600, -24'sd25600);
		send_target(-24'sd30000, -24'sd1);	// just below the negative x axis
		send_target(-24'sd30000, 24'sd0);
		send_target(24'sd51201, 24'sd0);	// one lsb out of reach
		send_target(24'sh7FFFFF, 24'sh7FFFFF);
		send_target(24'sh800000, 24'sh800000);
		send_target(24'sh800000, 24'sh7FFFFF);
		send_target(24'sd1, -24'sd1);
		// upper arm zero: den is zero, always out of reach
		set_lengths(23'd0, 23'd25600);
		send_target(24'sd25600, 24'sd0);
		send_target(24'sd0, 24'sd0);
		// biggest and smallest links
		set_lengths(23'h7FFFFF, 23'h7FFFFF);
		send_target(24'sh7FFFFF, 24'sh7FFFFF);
		send_target(24'sh800000, 24'sd0);
		send_target(24'sd0, 24'sd0);
		set_lengths(23'd1, 23'd1);
		send_target(24'sd2, 24'sd0);
		send_target(24'sd0, 24'sd0);
		send_target(-24'sd1, 24'sd1);
		set_lengths(23'h7FFFFF, 23'd0);
		send_target(24'sd100, 24'sd100);
	endtask

	// Phases of random points over several link settings and idle rates.
	task automatic test_random_points();
		logic [tlik_pkg::LEN_W-1:0] l1, l2;
		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: begin l1 = 23'd25600;   l2 = 23'd25600;   end
				1: begin l1 = 23'h7FFFFF;  l2 = 23'd1;       end
				2: begin l1 = 23'd1;       l2 = 23'h7FFFFF;  end
				3: begin l1 = 23'd3;       l2 = 23'd2;       end
				4: begin l1 = 23'h7FFFFF;  l2 = 23'h7FFFFF;  end
				default: begin
					l1 = 23'($urandom_range(1, MAX_LEN) >> $urandom_range(0, 20));
					l2 = 23'($urandom_range(1, MAX_LEN) >> $urandom_range(0, 20));
					if (l1 == 0) l1 = 23'd1;
					if (l2 == 0) l2 = 23'd1;
				end
			endcase
			set_lengths(l1, l2);
			// some phases run without any idling
			max_gap = (ph % 3 == 1) ? 0 : ((ph % 3 == 2) ? 3 : 18);
			for (int n = 0; n < 200; n++) begin
				if (n == 100)
					drain_pipe();	// hold off until the pipe is empty
				send_random_point();
			end
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = tlik_pkg::REG_UPPER_ARM;
		cfg_data         = '0;
		tgt_bus.valid    = 1'b0;
		tgt_bus.target_x = '0;
		tgt_bus.target_y = '0;
		upper_len        = 23'd25600;
		fore_len         = 23'd25600;
		mismatches       = 0;
		max_gap          = 18;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_points();
		set_lengths(23'd25600, 23'd25600);
		test_random_points();
		drain_pipe();

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/tlik_pkg.sv
rtl/core/tlik_if.sv
rtl/core/tlik_sqrt_cell.sv
rtl/core/tlik_cordic_cell.sv
rtl/core/tlik_atan2.sv
rtl/core/two_link_arm_inverse_kinematics_core.sv
test/tb_two_link_arm_inverse_kinematics_core.sv
